// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/core/i2cses_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cses_pkg
// Types and constants shared by the status event sequencer modules.
// ----------------------------------------------------------------------------
package i2cses_pkg;
    localparam int MaxMessageLength = 32;
    localparam int IdxW = $clog2(MaxMessageLength);
    localparam int CntW = 6;
    localparam logic [CntW-1:0] CountMax = '1;

    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_EVENT  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [4:0] EV_START      = 5'd0;
    localparam logic [4:0] EV_RSTART     = 5'd1;
    localparam logic [4:0] EV_SLAW_ACK   = 5'd2;
    localparam logic [4:0] EV_SLAW_NACK  = 5'd3;
    localparam logic [4:0] EV_DATA_ACK   = 5'd4;
    localparam logic [4:0] EV_DATA_NACK  = 5'd5;
    localparam logic [4:0] EV_SLAR_ACK   = 5'd6;
    localparam logic [4:0] EV_SLAR_NACK  = 5'd7;
    localparam logic [4:0] EV_RECV_ACK   = 5'd8;
    localparam logic [4:0] EV_RECV_NACK  = 5'd9;
    localparam logic [4:0] EV_SL_ADDR_A  = 5'd10;
    localparam logic [4:0] EV_SL_ADDR_B  = 5'd11;
    localparam logic [4:0] EV_SL_DATA_A  = 5'd12;
    localparam logic [4:0] EV_SL_DATA_N  = 5'd13;
    localparam logic [4:0] EV_STOP       = 5'd14;
    localparam logic [4:0] EV_BUS_ERR    = 5'd15;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SLAW_NACK = 3'd1;
    localparam logic [2:0] ERR_DATA_NACK = 3'd2;
    localparam logic [2:0] ERR_SLAR_NACK = 3'd3;
    localparam logic [2:0] ERR_SL_NACK   = 3'd4;

    localparam logic [3:0] CB_AA  = 4'b0001;
    localparam logic [3:0] CB_STO = 4'b0100;
    localparam logic [3:0] CB_ALL = 4'b1111;

    localparam logic ADDR_BUS_MODE = 1'b0;
    localparam logic ADDR_OWN      = 1'b1;

    // One accepted input word as it moves from front to back.
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] target_address;
        logic [4:0] send_length;
        logic [5:0] receive_length;
        logic [4:0] buffer_index;
        logic [7:0] buffer_byte;
        logic [4:0] status_event;
        logic [7:0] bus_byte;
    } item_t;

    typedef struct packed {
        logic       data_write_valid;
        logic [7:0] data_write_byte;
        logic [3:0] control_set;
        logic [3:0] control_clear;
        logic       notify_master;
        logic       notify_slave;
        logic [2:0] error_code;
        logic [5:0] received_count;
        logic [5:0] message_length;
        logic [7:0] read_byte;
    } result_t;

    function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
        return (c == CountMax) ? c : c + 1'b1;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/i2cses_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cses_front
// Input register that accepts words and holds them for the queue.
// ----------------------------------------------------------------------------
module i2cses_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire i2cses_pkg::item_t   in_item,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output i2cses_pkg::item_t        q_item
);
    import i2cses_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb
    begin
        valid_next = in_valid || (valid_reg && !q_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end
endmodule
`default_nettype wire

// ===== rtl/core/i2cses_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cses_queue
// Two-entry queue between the front register and the back end.
// ----------------------------------------------------------------------------
module i2cses_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire i2cses_pkg::item_t   wr_item,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output i2cses_pkg::item_t        rd_item
);
    import i2cses_pkg::*;

    item_t      mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_item;
    end
endmodule
`default_nettype wire

// ===== rtl/core/i2cses_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cses_back
// Executes one word per cycle unless stalled: buffers, counts, event decoding.
// ----------------------------------------------------------------------------
module i2cses_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                bus_mode,
    input  wire logic [7:0]          own_address,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire i2cses_pkg::item_t   q_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output i2cses_pkg::result_t      out_res
);
    import i2cses_pkg::*;

    logic [7:0] send_mem [MaxMessageLength];
    logic [7:0] recv_mem [MaxMessageLength];

    logic [CntW-1:0] scnt_reg, scnt_next;
    logic [CntW-1:0] rcnt_reg, rcnt_next;
    logic [6:0]      maddr_reg, maddr_next;
    logic [4:0]      mslen_reg, mslen_next;
    logic [5:0]      mrlen_reg, mrlen_next;
    logic [2:0]      err_reg, err_next;
    logic            ovalid_reg;
    result_t         res_reg;
    result_t         res;
    logic            fire;
    logic [3:0]      c;
    logic            rx_we;
    logic [IdxW-1:0] rx_idx;
    logic [7:0]      rx_data;
    logic            tx_use;
    logic            tx_hit;
    logic [CntW:0]   rcnt_p1;
    logic [7:0]      mem_byte_reg;
    logic            tx_sel_reg;
    logic            rd_sel_reg;

    assign q_ready   = !ovalid_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ovalid_reg;
    assign tx_hit    = (scnt_reg < CntW'(MaxMessageLength));
    assign rcnt_p1   = {1'b0, rcnt_reg} + 1'b1;

    // Buffer bytes are read into a register together with the result and
    // merged into the result word here.
    always_comb
    begin
        out_res = res_reg;
        if (tx_sel_reg)
            out_res.data_write_byte = mem_byte_reg;
        if (rd_sel_reg)
            out_res.read_byte = mem_byte_reg;
    end

    always_comb
    begin
        scnt_next  = scnt_reg;
        rcnt_next  = rcnt_reg;
        maddr_next = maddr_reg;
        mslen_next = mslen_reg;
        mrlen_next = mrlen_reg;
        err_next   = err_reg;
        c          = CB_ALL;
        rx_we      = 1'b0;
        rx_idx     = rcnt_reg[IdxW-1:0];
        rx_data    = q_item.bus_byte;
        tx_use     = 1'b0;
        res        = '0;
        case (q_item.op)
            OP_HEADER:
            begin
                maddr_next = q_item.target_address;
                mslen_next = q_item.send_length;
                mrlen_next = q_item.receive_length;
                err_next   = ERR_NONE;
            end
            OP_WRITE, OP_READ: ;
            default:
            begin
                case (q_item.status_event)
                    EV_START, EV_RSTART:
                    begin
                        rcnt_next = '0;
                        scnt_next = '0;
                        res.data_write_valid = 1'b1;
                        res.data_write_byte  = {maddr_reg, mslen_reg == 5'd0};
                    end
                    EV_SLAW_ACK:
                    begin
                        res.data_write_valid = 1'b1;
                        tx_use    = 1'b1;
                        scnt_next = bump(scnt_reg);
                    end
                    EV_SLAW_NACK:
                    begin
                        c = c & ~CB_STO; err_next = ERR_SLAW_NACK;
                        res.notify_master = 1'b1;
                    end
                    EV_DATA_ACK:
                    begin
                        if ({1'b0, mslen_reg} != scnt_reg)
                        begin
                            res.data_write_valid = 1'b1;
                            tx_use    = 1'b1;
                            scnt_next = bump(scnt_reg);
                        end
                        else
                        begin
                            c = c & ~CB_STO;
                            res.notify_master = 1'b1;
                        end
                    end
                    EV_DATA_NACK:
                    begin
                        c = c & ~CB_STO; err_next = ERR_DATA_NACK;
                        res.notify_master = 1'b1;
                    end
                    EV_SLAR_ACK:
                        if (mrlen_reg > 6'd1) c = c & ~CB_AA;
                    EV_SLAR_NACK:
                    begin
                        c = c & ~CB_STO; err_next = ERR_SLAR_NACK;
                        res.notify_master = 1'b1;
                    end
                    EV_RECV_ACK:
                    begin
                        if (rcnt_p1 < (CntW+1)'(MaxMessageLength))
                        begin
                            rx_we     = 1'b1;
                            rcnt_next = bump(rcnt_reg);
                            if ({1'b0, rcnt_next} + 1'b1 != {1'b0, mrlen_reg})
                                c = c & ~CB_AA;
                        end
                    end
                    EV_RECV_NACK:
                    begin
                        rx_we     = rcnt_reg < CntW'(MaxMessageLength);
                        rcnt_next = bump(rcnt_reg);
                        c = c & ~CB_STO;
                        res.notify_master = 1'b1;
                    end
                    EV_SL_ADDR_A, EV_SL_ADDR_B:
                    begin
                        rcnt_next = '0;
                        if (!bus_mode)
                        begin
                            rx_we     = 1'b1;
                            rx_idx    = '0;
                            rx_data   = own_address;
                            c = c & ~CB_AA;
                            rcnt_next = CntW'(1);
                        end
                    end
                    EV_SL_DATA_A:
                    begin
                        if (rcnt_reg < CntW'(MaxMessageLength))
                        begin
                            rx_we     = 1'b1;
                            rcnt_next = bump(rcnt_reg);
                            c = c & ~CB_AA;
                        end
                    end
                    EV_SL_DATA_N:
                    begin
                        c = c & ~CB_AA; err_next = ERR_SL_NACK;
                    end
                    EV_STOP:
                    begin
                        mrlen_next = rcnt_reg;
                        res.notify_slave = (bus_mode && rcnt_reg > 6'd0) ||
                                           (!bus_mode && rcnt_reg > 6'd1);
                        c = c & ~CB_AA;
                    end
                    EV_BUS_ERR:
                        c = c & ~CB_STO;
                    default: ;
                endcase
                if ((c & CB_STO) == 4'd0) c = c & ~CB_AA;
                res.control_clear = c;
                res.control_set   = c ^ CB_ALL;
            end
        endcase
        res.error_code     = err_next;
        res.received_count = rcnt_next;
        res.message_length = mrlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg   <= '0;
            rcnt_reg   <= '0;
            maddr_reg  <= '0;
            mslen_reg  <= '0;
            mrlen_reg  <= '0;
            err_reg    <= ERR_NONE;
            ovalid_reg <= 1'b0;
            tx_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                scnt_reg   <= scnt_next;
                rcnt_reg   <= rcnt_next;
                maddr_reg  <= maddr_next;
                mslen_reg  <= mslen_next;
                mrlen_reg  <= mrlen_next;
                err_reg    <= err_next;
                tx_sel_reg <= tx_use;
                rd_sel_reg <= (q_item.op == OP_READ);
            end
            if (q_ready)
                ovalid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res;
        if (fire)
        begin
            if (tx_use)
                mem_byte_reg <= tx_hit ? send_mem[scnt_reg[IdxW-1:0]] : 8'h00;
            else
                mem_byte_reg <= recv_mem[q_item.buffer_index];
        end
        if (fire && q_item.op == OP_WRITE)
            send_mem[q_item.buffer_index] <= q_item.buffer_byte;
        if (fire && rx_we)
            recv_mem[rx_idx] <= rx_data;
    end
endmodule
`default_nettype wire

// ===== rtl/core/i2c_status_event_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_status_event_sequencer
// Sequences an I2C controller from its status events and buffers messages.
// ----------------------------------------------------------------------------
// Path: a word passes the input register, the queue and the result register.
// Throughput: one word per cycle while the output is not stalled, set by the
// back-end execute.
// Reset: asynchronous, active low; counts, header, error and valids clear,
// the transmit and receive buffers keep undefined contents until written.
module i2c_status_event_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op, target_address, send_length, receive_length, buffer_index,
    // buffer_byte, status_event, bus_byte (from bit 0 up), 2 pad bits
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_write_valid, data_write_byte, control_set, control_clear,
    // notify_master, notify_slave, error_code, received_count,
    // message_length, read_byte (from bit 0 up), 6 pad bits
    output logic [47:0]      m_tdata
);
    import i2cses_pkg::*;

    logic       bus_mode_reg;
    logic [7:0] own_address_reg;
    item_t      in_item, f_item, b_item;
    logic       f_valid, f_ready, b_valid, b_ready;
    result_t    res;

    // Configuration: byte address 4*i, written in the APB access phase.
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            ADDR_BUS_MODE: prdata = {31'd0, bus_mode_reg};
            default:       prdata = {24'd0, own_address_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_mode_reg    <= 1'b0;
            own_address_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == ADDR_BUS_MODE)
                bus_mode_reg <= pwdata[0];
            else
                own_address_reg <= pwdata[7:0];
        end
    end

    assign in_item = '{op:             s_tdata[1:0],
                       target_address: s_tdata[8:2],
                       send_length:    s_tdata[13:9],
                       receive_length: s_tdata[19:14],
                       buffer_index:   s_tdata[24:20],
                       buffer_byte:    s_tdata[32:25],
                       status_event:   s_tdata[37:33],
                       bus_byte:       s_tdata[45:38]};

    i2cses_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
    );

    i2cses_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    i2cses_back u_back (
        .clk(clk), .rst_n(rst_n),
        .bus_mode(bus_mode_reg), .own_address(own_address_reg),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {6'd0, res.read_byte, res.message_length, res.received_count,
                      res.error_code, res.notify_slave, res.notify_master,
                      res.control_clear, res.control_set, res.data_write_byte,
                      res.data_write_valid};
endmodule
`default_nettype wire

// ===== rtl/core/i2cses_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// i2cses_checker
// Port-level checks of the status event sequencer.
// ----------------------------------------------------------------------------
module i2cses_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        pready
);
    logic [3:0] cset;
    logic [3:0] cclr;
    logic [2:0] ecode;

    assign cset  = m_tdata[12:9];
    assign cclr  = m_tdata[16:13];
    assign ecode = m_tdata[21:19];

    // Control set and clear are complements on every event result.
    `ASSERT_CLK(a_ctrl, clk, rst_n, m_tvalid && (cset | cclr) != 4'd0 |-> (cset ^ cclr) == 4'hF, "control set and clear disagree")
    // A stalled result holds.
    `ASSERT_CLK(a_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    // Error code never exceeds the defined range.
    `ASSERT_CLK(a_err, clk, rst_n, m_tvalid |-> ecode <= 3'd4, "error code out of range")
    `ASSERT_ALWAYS(a_rdy, clk, pready, "pready dropped")
endmodule

bind i2c_status_event_sequencer i2cses_checker u_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .pready(pready)
);
`default_nettype wire

// ===== tb/sv/tb_i2c_status_event_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_status_event_sequencer
// Self-checking bench for the I2C status event sequencer. Input words carry
// headers, transmit and receive buffer accesses and controller status events.
// A local predictor keeps its own copy of the message, buffers and counts and
// checks every result word field by field. A short directed table is followed
// by random master and slave transactions mixed with noise, under random
// idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_i2c_status_event_sequencer;
    import i2cses_pkg::*;

    localparam int NumRandom = 1350;
    localparam int WatchdogLimit = 5000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    // op, target_address, send_length, receive_length, buffer_index,
    // buffer_byte, status_event, bus_byte (from bit 0 up), 2 pad bits
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // data_write_valid, data_write_byte, control_set, control_clear,
    // notify_master, notify_slave, error_code, received_count,
    // message_length, read_byte (from bit 0 up), 6 pad bits
    logic [47:0] m_tdata;

    i2c_status_event_sequencer u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state: a private copy of everything the block remembers.
    logic [7:0] tx_mem [MaxMessageLength];
    logic [7:0] rx_mem [MaxMessageLength];
    bit         rx_written [MaxMessageLength];
    logic [5:0] tx_cnt;
    logic [5:0] rx_cnt;
    logic [6:0] hdr_addr;
    logic [4:0] hdr_send_len;
    logic [5:0] hdr_recv_len;
    logic [2:0] err_reg;
    logic       mode_local;
    logic [7:0] own_addr_byte;

    result_t    expected_results[$];
    int         mismatches;
    int         words_sent;
    int         words_checked;
    int         idle_cycles;
    bit         stall_long;
    bit         phase_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Packing helpers for the stream words.
    // ------------------------------------------------------------------
    function automatic logic [47:0] pack_word(input item_t it);
        return {2'd0, it.bus_byte, it.status_event, it.buffer_byte, it.buffer_index,
                it.receive_length, it.send_length, it.target_address, it.op};
    endfunction

    function automatic result_t unpack_result(input logic [47:0] d);
        result_t r;
        r.data_write_valid = d[0];
        r.data_write_byte  = d[8:1];
        r.control_set      = d[12:9];
        r.control_clear    = d[16:13];
        r.notify_master    = d[17];
        r.notify_slave     = d[18];
        r.error_code       = d[21:19];
        r.received_count   = d[27:22];
        r.message_length   = d[33:28];
        r.read_byte        = d[41:34];
        return r;
    endfunction

    function automatic logic [5:0] count_up(input logic [5:0] c);
        return (c == 6'd63) ? c : c + 6'd1;
    endfunction

    function automatic logic [7:0] tx_fetch(input logic [5:0] i);
        return (i < MaxMessageLength) ? tx_mem[i[4:0]] : 8'd0;
    endfunction

    task automatic rx_store(input logic [5:0] i, input logic [7:0] v);
        if (i < MaxMessageLength)
        begin
            rx_mem[i[4:0]] = v;
            rx_written[i[4:0]] = 1'b1;
        end
    endtask

    // Works out the result word of one input word and advances the state.
    task automatic sequence_word(input item_t it, output result_t r);
        logic [3:0] clr_bits;
        r = '0;
        case (it.op)
            OP_HEADER:
            begin
                hdr_addr = it.target_address;
                hdr_send_len = it.send_length;
                hdr_recv_len = it.receive_length;
                err_reg = ERR_NONE;
            end
            OP_WRITE:
                tx_mem[it.buffer_index] = it.buffer_byte;
            OP_READ:
                r.read_byte = rx_mem[it.buffer_index];
            default:
            begin
                clr_bits = CB_ALL;
                case (it.status_event)
                    EV_START, EV_RSTART:
                    begin
                        rx_cnt = '0;
                        tx_cnt = '0;
                        r.data_write_valid = 1'b1;
                        r.data_write_byte = {hdr_addr, hdr_send_len == 5'd0};
                    end
                    EV_SLAW_ACK:
                    begin
                        r.data_write_valid = 1'b1;
                        r.data_write_byte = tx_fetch(tx_cnt);
                        tx_cnt = count_up(tx_cnt);
                    end
                    EV_SLAW_NACK:
                    begin
                        clr_bits &= ~CB_STO;
                        err_reg = ERR_SLAW_NACK;
                        r.notify_master = 1'b1;
                    end
                    EV_DATA_ACK:
                    begin
                        if ({1'b0, hdr_send_len} != tx_cnt)
                        begin
                            r.data_write_valid = 1'b1;
                            r.data_write_byte = tx_fetch(tx_cnt);
                            tx_cnt = count_up(tx_cnt);
                        end
                        else
                        begin
                            clr_bits &= ~CB_STO;
                            r.notify_master = 1'b1;
                        end
                    end
                    EV_DATA_NACK:
                    begin
                        clr_bits &= ~CB_STO;
                        err_reg = ERR_DATA_NACK;
                        r.notify_master = 1'b1;
                    end
                    EV_SLAR_ACK:
                        if (hdr_recv_len > 6'd1)
                            clr_bits &= ~CB_AA;
                    EV_SLAR_NACK:
                    begin
                        clr_bits &= ~CB_STO;
                        err_reg = ERR_SLAR_NACK;
                        r.notify_master = 1'b1;
                    end
                    EV_RECV_ACK:
                        if (int'(rx_cnt) + 1 < MaxMessageLength)
                        begin
                            rx_store(rx_cnt, it.bus_byte);
                            rx_cnt = count_up(rx_cnt);
                            if (int'(rx_cnt) + 1 != int'(hdr_recv_len))
                                clr_bits &= ~CB_AA;
                        end
                    EV_RECV_NACK:
                    begin
                        rx_store(rx_cnt, it.bus_byte);
                        rx_cnt = count_up(rx_cnt);
                        clr_bits &= ~CB_STO;
                        r.notify_master = 1'b1;
                    end
                    EV_SL_ADDR_A, EV_SL_ADDR_B:
                    begin
                        rx_cnt = '0;
                        if (!mode_local)
                        begin
                            rx_store(6'd0, own_addr_byte);
                            clr_bits &= ~CB_AA;
                            rx_cnt = 6'd1;
                        end
                    end
                    EV_SL_DATA_A:
                        if (rx_cnt < MaxMessageLength)
                        begin
                            rx_store(rx_cnt, it.bus_byte);
                            rx_cnt = count_up(rx_cnt);
                            clr_bits &= ~CB_AA;
                        end
                    EV_SL_DATA_N:
                    begin
                        clr_bits &= ~CB_AA;
                        err_reg = ERR_SL_NACK;
                    end
                    EV_STOP:
                    begin
                        hdr_recv_len = rx_cnt;
                        if ((mode_local && rx_cnt > 0) || (!mode_local && rx_cnt > 1))
                            r.notify_slave = 1'b1;
                        clr_bits &= ~CB_AA;
                    end
                    EV_BUS_ERR:
                        clr_bits &= ~CB_STO;
                    default:
                        ;
                endcase
                // When STO is set, the acknowledge bit is set along with it.
                if ((clr_bits & CB_STO) == 4'd0)
                    clr_bits &= ~CB_AA;
                r.control_clear = clr_bits;
                r.control_set = clr_bits ^ CB_ALL;
            end
        endcase
        r.error_code = err_reg;
        r.received_count = rx_cnt;
        r.message_length = hdr_recv_len;
    endtask

    // ------------------------------------------------------------------
    // Register access, only while the block is idle.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == 3'd4 * ADDR_BUS_MODE)
            mode_local = data[0];
        else
            own_addr_byte = data[7:0];
    endtask

    task automatic set_mode(input logic local_mode, input logic [7:0] own);
        apb_write(3'd4 * ADDR_BUS_MODE, {31'd0, local_mode});
        apb_write(3'd4 * ADDR_OWN, {24'd0, own});
    endtask

    // Sends one word after a random gap; the prediction is queued at accept.
    task automatic send_word(input item_t it, input bit has_golden, input result_t golden);
        result_t r;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge clk);
        s_tdata = pack_word(it);
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sequence_word(it, r);
        if (has_golden && r != golden)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Directed row predictor disagreement: table %h predictor %h",
                         golden, r);
        end
        expected_results.push_back(r);
        words_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic item_t make_item(input logic [1:0] op, input logic [4:0] ev,
                                        input logic [7:0] bb);
        item_t it;
        it = '0;
        it.op = op;
        it.status_event = ev;
        it.bus_byte = bb;
        return it;
    endfunction

    // Random word of any kind; only received entries are ever read back.
    function automatic item_t noise_item();
        item_t it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = item_t'(raw[$bits(item_t)-1:0]);
        if (it.receive_length > 6'd32)
            it.receive_length = 6'($urandom_range(0, 32));
        if (it.op == OP_READ && !rx_written[it.buffer_index])
            it.op = OP_EVENT;
        return it;
    endfunction

    // A well-formed master write, read or slave receive, or 1 to 4 noise words.
    task automatic random_transaction();
        item_t it;
        result_t none;
        int kind;
        int len;
        none = '0;
        kind = $urandom_range(0, 9);
        it = '0;
        it.op = OP_HEADER;
        it.target_address = 7'($urandom);
        it.send_length = $urandom_range(0, 6) == 0 ? 5'd31 : 5'($urandom_range(0, 6));
        it.receive_length = $urandom_range(0, 6) == 0 ? 6'd32
                                                       : 6'($urandom_range(0, 6));
        send_word(it, 1'b0, none);
        if (kind < 3)
        begin
            len = int'(it.send_length);
            for (int i = 0; i < len && i < 8; i++)
            begin
                it = make_item(OP_WRITE, 5'd0, 8'd0);
                it.buffer_index = 5'(i);
                it.buffer_byte = 8'($urandom);
                send_word(it, 1'b0, none);
            end
            send_word(make_item(OP_EVENT, EV_START, 8'($urandom)), 1'b0, none);
            send_word(make_item(OP_EVENT, $urandom_range(0, 7) == 0 ? EV_SLAW_NACK
                                                                    : EV_SLAW_ACK,
                                8'($urandom)), 1'b0, none);
            for (int i = 0; i <= len && i < 10; i++)
                send_word(make_item(OP_EVENT, $urandom_range(0, 9) == 0 ? EV_DATA_NACK
                                                                        : EV_DATA_ACK,
                                    8'($urandom)), 1'b0, none);
        end
        else if (kind < 6)
        begin
            send_word(make_item(OP_EVENT, EV_RSTART, 8'($urandom)), 1'b0, none);
            send_word(make_item(OP_EVENT, $urandom_range(0, 7) == 0 ? EV_SLAR_NACK
                                                                    : EV_SLAR_ACK,
                                8'($urandom)), 1'b0, none);
            len = $urandom_range(0, 7);
            repeat (len)
                send_word(make_item(OP_EVENT, EV_RECV_ACK, 8'($urandom)), 1'b0, none);
            send_word(make_item(OP_EVENT, EV_RECV_NACK, 8'($urandom)), 1'b0, none);
        end
        else if (kind < 9)
        begin
            send_word(make_item(OP_EVENT, $urandom_range(0, 1) ? EV_SL_ADDR_A
                                                               : EV_SL_ADDR_B,
                                8'($urandom)), 1'b0, none);
            len = $urandom_range(0, 12) == 0 ? 40 : $urandom_range(0, 6);
            repeat (len)
                send_word(make_item(OP_EVENT, $urandom_range(0, 12) == 0 ? EV_SL_DATA_N
                                                                         : EV_SL_DATA_A,
                                    8'($urandom)), 1'b0, none);
            send_word(make_item(OP_EVENT, EV_STOP, 8'($urandom)), 1'b0, none);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_word(noise_item(), 1'b0, none);
        end
        // Read back part of what has been received.
        for (int i = 0; i < MaxMessageLength; i++)
            if (rx_written[i] && $urandom_range(0, 7) == 0)
            begin
                it = make_item(OP_READ, 5'd0, 8'd0);
                it.buffer_index = 5'(i);
                send_word(it, 1'b0, none);
            end
    endtask

    // ------------------------------------------------------------------
    // Directed table: rows with a typed golden result are compared against
    // the predictor too, the others rely on the predictor alone.
    // ------------------------------------------------------------------
    typedef struct {
        item_t   it;
        bit      has_golden;
        result_t golden;
    } row_t;

    localparam logic [4:0] EvList [11] = '{
        EV_RSTART, EV_SLAW_ACK, EV_DATA_ACK, EV_SLAR_ACK, EV_RECV_ACK,
        EV_RECV_NACK, EV_SL_ADDR_A, EV_SL_ADDR_B, EV_SL_DATA_A, EV_STOP, EV_BUS_ERR
    };

    function automatic result_t gold(input logic [7:0] wb, input logic wv,
                                     input logic [3:0] clr, input logic nm,
                                     input logic [2:0] err, input logic [5:0] rc,
                                     input logic [5:0] ml);
        result_t r;
        r = '0;
        r.data_write_valid = wv;
        r.data_write_byte = wb;
        r.control_clear = clr;
        r.control_set = (wv || clr != 4'd0 || nm) ? clr ^ CB_ALL : 4'd0;
        r.notify_master = nm;
        r.error_code = err;
        r.received_count = rc;
        r.message_length = ml;
        return r;
    endfunction

    task automatic run_directed();
        row_t rows[$];
        row_t rw;
        item_t it;
        result_t nogold;
        nogold = '0;
        // Ignored event straight after reset clears all four control bits.
        rw.it = make_item(OP_EVENT, 5'd31, 8'hFF);
        rw.has_golden = 1'b1;
        rw.golden = gold(8'd0, 1'b0, CB_ALL, 1'b0, ERR_NONE, 6'd0, 6'd0);
        rows.push_back(rw);
        // SLA+W nack raises error one and stops.
        rw.it = make_item(OP_EVENT, EV_SLAW_NACK, 8'd0);
        rw.golden = gold(8'd0, 1'b0, CB_ALL & ~CB_STO & ~CB_AA, 1'b1, ERR_SLAW_NACK,
                         6'd0, 6'd0);
        rows.push_back(rw);
        // Header at its extremes clears the error.
        it = '0;
        it.op = OP_HEADER;
        it.target_address = 7'h7F;
        it.send_length = 5'd31;
        it.receive_length = 6'd32;
        rw.it = it;
        rw.golden = gold(8'd0, 1'b0, 4'd0, 1'b0, ERR_NONE, 6'd0, 6'd32);
        rows.push_back(rw);
        rw.it = make_item(OP_EVENT, EV_START, 8'd0);
        rw.golden = gold(8'hFE, 1'b1, CB_ALL, 1'b0, ERR_NONE, 6'd0, 6'd32);
        rows.push_back(rw);
        // Data nack: error two only.
        rw.it = make_item(OP_EVENT, EV_DATA_NACK, 8'd0);
        rw.golden = gold(8'd0, 1'b0, CB_ALL & ~CB_STO & ~CB_AA, 1'b1, ERR_DATA_NACK,
                         6'd0, 6'd32);
        rows.push_back(rw);
        rw.it = make_item(OP_EVENT, EV_SLAR_NACK, 8'd0);
        rw.golden = gold(8'd0, 1'b0, CB_ALL & ~CB_STO & ~CB_AA, 1'b1, ERR_SLAR_NACK,
                         6'd0, 6'd32);
        rows.push_back(rw);
        rw.it = make_item(OP_EVENT, EV_SL_DATA_N, 8'd0);
        rw.golden = gold(8'd0, 1'b0, CB_ALL & ~CB_AA, 1'b0, ERR_SL_NACK, 6'd0, 6'd32);
        rows.push_back(rw);
        rw.has_golden = 1'b0;
        rw.golden = nogold;
        // Fill the whole transmit buffer so that every later fetch finds data.
        for (int i = 0; i < MaxMessageLength; i++)
        begin
            it = make_item(OP_WRITE, 5'd0, 8'd0);
            it.buffer_index = 5'(i);
            it.buffer_byte = 8'(i * 37 + 11);
            rw.it = it;
            rows.push_back(rw);
        end
        // Transmit bytes at both ends of the buffer and extreme values.
        it = make_item(OP_WRITE, 5'd0, 8'd0);
        it.buffer_index = 5'd0;
        it.buffer_byte = 8'hFF;
        rw.it = it;
        rows.push_back(rw);
        it.buffer_index = 5'd31;
        it.buffer_byte = 8'h00;
        rw.it = it;
        rows.push_back(rw);
        foreach (EvList[k])
        begin
            rw.it = make_item(OP_EVENT, EvList[k], 8'hA5 ^ 8'(k));
            rows.push_back(rw);
        end
        // Read back the receive entry just stored by the slave address.
        it = make_item(OP_READ, 5'd0, 8'd0);
        it.buffer_index = 5'd0;
        rw.it = it;
        rows.push_back(rw);
        foreach (rows[k])
            send_word(rows[k].it, rows[k].has_golden, rows[k].golden);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, one long hold-off, and the checker.
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_long)
            begin
                m_tready = 1'b0;
                repeat (200) @(negedge clk);
                stall_long = 1'b0;
            end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
            if (gap != 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = unpack_result(m_tdata);
            words_checked++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", m_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d mismatch: expected %p got %p",
                                 words_checked, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        idle_cycles = 0;
        stall_long = 1'b0;
        tx_cnt = '0;
        rx_cnt = '0;
        hdr_addr = '0;
        hdr_send_len = '0;
        hdr_recv_len = '0;
        err_reg = ERR_NONE;
        mode_local = 1'b0;
        own_addr_byte = '0;
        foreach (tx_mem[i])
        begin
            tx_mem[i] = '0;
            rx_mem[i] = '0;
            rx_written[i] = 1'b0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        set_mode(1'b0, 8'hFF);
        run_directed();
        wait_drained();
        // Four settings, the extremes among them, each a share of the run.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_mode(1'b1, 8'h00);
                1: set_mode(1'b0, 8'h00);
                2: set_mode(1'b1, 8'hFF);
                default: set_mode(1'b0, 8'($urandom));
            endcase
            if (phase == 1)
                stall_long = 1'b1;
            while (words_sent < 25 + (phase + 1) * NumRandom / 4)
                random_transaction();
            wait_drained();
        end
        $display("Covered %0d input words over directed rows and random master, slave",
                 words_sent);
        $display("and noise traffic in both bus modes; %0d result words checked.",
                 words_checked);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/i2cses_pkg.sv
rtl/core/i2cses_front.sv
rtl/core/i2cses_queue.sv
rtl/core/i2cses_back.sv
rtl/core/i2c_status_event_sequencer.sv
rtl/core/i2cses_checker.sv
tb/sv/tb_i2c_status_event_sequencer.sv
